[src/pds_pkg.sv]
// Shared types and constants for the PLL divider search unit.
`default_nettype none

package pds_pkg;

   localparam int unsigned HZ_PER_KHZ = 1000;

   // Configuration register indexes
   localparam logic [2:0] CSR_PRESCALER_MIN  = 3'd0;
   localparam logic [2:0] CSR_PRESCALER_MAX  = 3'd1;
   localparam logic [2:0] CSR_MULTIPLIER_MIN = 3'd2;
   localparam logic [2:0] CSR_MULTIPLIER_MAX = 3'd3;
   localparam logic [2:0] CSR_REF_MIN_KHZ    = 3'd4;
   localparam logic [2:0] CSR_REF_MAX_KHZ    = 3'd5;
   localparam logic [2:0] CSR_OUTPUT_HALVE   = 3'd6;

   // Reset values
   localparam logic [5:0]  RST_PRESCALER_MIN  = 6'd1;
   localparam logic [5:0]  RST_PRESCALER_MAX  = 6'd25;
   localparam logic [5:0]  RST_MULTIPLIER_MIN = 6'd24;
   localparam logic [5:0]  RST_MULTIPLIER_MAX = 6'd55;
   localparam logic [15:0] RST_REF_MIN_KHZ    = 16'd2000;
   localparam logic [15:0] RST_REF_MAX_KHZ    = 16'd4000;

   // Divider step counts: 16-bit reference quotient, 32-bit clock quotient
   localparam logic [5:0] REF_DIV_STEPS = 6'd16;
   localparam logic [5:0] HZ_DIV_STEPS  = 6'd32;

   typedef struct packed {
      logic [15:0] osc_khz;
      logic [17:0] target_khz;
   } req_type;

   typedef struct packed {
      logic        no_solution;
      logic [4:0]  prescaler_code;
      logic [5:0]  multiplier_code;
      logic [31:0] core_clock_hz;
   } rsp_type;

   typedef struct packed {
      logic [5:0]  prescaler_min;
      logic [5:0]  prescaler_max;
      logic [5:0]  multiplier_min;
      logic [5:0]  multiplier_max;
      logic [15:0] ref_min_khz;
      logic [15:0] ref_max_khz;
      logic        output_halve;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic ref_start;
      logic inner_init;
      logic step;
      logic p_next;
      logic hz_start;
      logic out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic div_busy;
      logic p_empty;
      logic v_empty;
      logic p_zero;
      logic p_last;
      logic ref_ok;
      logic v_last;
      logic exact;
      logic found;
      logic out_free;
   } ctrl_sts_type;

endpackage

`default_nettype wire

[src/pds_div.sv]
// Restoring divider, one quotient bit per cycle, 6-bit divisor.
`default_nettype none

module pds_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [5:0]  divisor,
   input  wire logic [5:0]  steps,
   output logic             busy,
   output logic [31:0]      quotient,
   output logic [5:0]       remainder
);
   import pds_pkg::*;

   logic [31:0] dq_ff, dq_in;
   logic [5:0]  rem_ff, rem_in;
   logic [5:0]  dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [6:0]  trial;
   logic        ge;

   assign trial = {rem_ff, dq_ff[31]};
   assign ge    = trial >= {1'b0, dvs_ff};

   always_comb begin
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         dq_in   = dividend;
         rem_in  = 6'd0;
         dvs_in  = divisor;
         cnt_in  = steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? 6'(trial - {1'b0, dvs_ff}) : trial[5:0];
         dq_in   = {dq_ff[30:0], ge};
         cnt_in  = cnt_ff - 6'd1;
         busy_in = (cnt_ff != 6'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign busy      = busy_ff;
   assign quotient  = dq_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

[src/pds_datapath.sv]
// Search datapath: loop counters, incremental clock quotient, best-pair tracking, result register.
`default_nettype none

module pds_datapath (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire pds_pkg::cfg_type      cfg,
   input  wire pds_pkg::ctrl_cmd_type cmd,
   output pds_pkg::ctrl_sts_type      sts,
   input  wire pds_pkg::req_type      req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output pds_pkg::rsp_type           rsp_data
);
   import pds_pkg::*;

   logic [15:0] osc_ff, osc_in;
   logic [17:0] target_ff, target_in;
   logic [25:0] osc_k_ff, osc_k_in;
   logic [5:0]  p_ff, p_in;
   logic [5:0]  v_ff, v_in;
   logic [15:0] qo_ff, qo_in;
   logic [5:0]  ro_ff, ro_in;
   logic [21:0] acc_q_ff, acc_q_in;
   logic [5:0]  acc_r_ff, acc_r_in;
   logic        found_ff, found_in;
   logic [21:0] best_diff_ff, best_diff_in;
   logic [5:0]  best_p_ff, best_p_in;
   logic [5:0]  best_v_ff, best_v_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic        div_busy;
   logic [31:0] div_q;
   logic [5:0]  div_r;
   logic [31:0] div_dividend;
   logic [5:0]  div_divisor;
   logic [5:0]  div_steps;

   logic [21:0] clk_val;
   logic [21:0] target_ext;
   logic [21:0] diff;
   logic        eval;
   logic [6:0]  sum_r;
   logic        wrap;
   logic [31:0] hz_clk;

   always_comb begin
      if (cmd.hz_start) begin
         div_dividend = 32'(osc_k_ff) * 32'(best_v_ff);
         div_divisor  = best_p_ff;
         div_steps    = HZ_DIV_STEPS;
      end else begin
         div_dividend = {osc_ff, 16'h0000};
         div_divisor  = p_ff;
         div_steps    = REF_DIV_STEPS;
      end
   end

   pds_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.ref_start | cmd.hz_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .steps     (div_steps),
      .busy      (div_busy),
      .quotient  (div_q),
      .remainder (div_r)
   );

   // evaluation of the current multiplier
   assign clk_val    = cfg.output_halve ? {1'b0, acc_q_ff[21:1]} : acc_q_ff;
   assign target_ext = {4'h0, target_ff};
   assign diff       = (clk_val >= target_ext) ? clk_val - target_ext : target_ext - clk_val;
   assign eval       = v_ff >= cfg.multiplier_min;

   // osc*(v+1)/p from osc*v/p: add osc/p and osc%p, fold the remainder once
   assign sum_r = {1'b0, acc_r_ff} + {1'b0, ro_ff};
   assign wrap  = sum_r >= {1'b0, p_ff};

   assign hz_clk = cfg.output_halve ? {1'b0, div_q[31:1]} : div_q;

   always_comb begin
      osc_in       = osc_ff;
      target_in    = target_ff;
      osc_k_in     = osc_k_ff;
      p_in         = p_ff;
      v_in         = v_ff;
      qo_in        = qo_ff;
      ro_in        = ro_ff;
      acc_q_in     = acc_q_ff;
      acc_r_in     = acc_r_ff;
      found_in     = found_ff;
      best_diff_in = best_diff_ff;
      best_p_in    = best_p_ff;
      best_v_in    = best_v_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (cmd.load) begin
         osc_in    = req_data.osc_khz;
         target_in = req_data.target_khz;
         osc_k_in  = 26'(req_data.osc_khz * 26'(HZ_PER_KHZ));
         p_in      = cfg.prescaler_min;
         found_in  = 1'b0;
      end
      if (cmd.p_next) begin
         p_in = p_ff + 6'd1;
      end
      if (cmd.inner_init) begin
         qo_in    = div_q[15:0];
         ro_in    = div_r;
         v_in     = 6'd0;
         acc_q_in = 22'd0;
         acc_r_in = 6'd0;
      end
      if (cmd.step) begin
         if (eval && (!found_ff || diff < best_diff_ff)) begin
            found_in     = 1'b1;
            best_diff_in = diff;
            best_p_in    = p_ff;
            best_v_in    = v_ff;
         end
         acc_r_in = wrap ? 6'(sum_r - {1'b0, p_ff}) : sum_r[5:0];
         acc_q_in = acc_q_ff + {6'h00, qo_ff} + {21'h0, wrap};
         v_in     = v_ff + 6'd1;
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         if (found_ff) begin
            rsp_in.no_solution     = 1'b0;
            rsp_in.prescaler_code  = 5'(best_p_ff - cfg.prescaler_min);
            rsp_in.multiplier_code = best_v_ff - cfg.multiplier_min;
            rsp_in.core_clock_hz   = hz_clk;
         end else begin
            rsp_in.no_solution     = 1'b1;
            rsp_in.prescaler_code  = 5'd0;
            rsp_in.multiplier_code = 6'd0;
            rsp_in.core_clock_hz   = 32'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
      end
      osc_ff       <= osc_in;
      target_ff    <= target_in;
      osc_k_ff     <= osc_k_in;
      p_ff         <= p_in;
      v_ff         <= v_in;
      qo_ff        <= qo_in;
      ro_ff        <= ro_in;
      acc_q_ff     <= acc_q_in;
      acc_r_ff     <= acc_r_in;
      best_diff_ff <= best_diff_in;
      best_p_ff    <= best_p_in;
      best_v_ff    <= best_v_in;
      rsp_ff       <= rsp_in;
   end

   always_comb begin
      sts.div_busy = div_busy;
      sts.p_empty  = cfg.prescaler_min > cfg.prescaler_max;
      sts.v_empty  = cfg.multiplier_min > cfg.multiplier_max;
      sts.p_zero   = p_ff == 6'd0;
      sts.p_last   = p_ff == cfg.prescaler_max;
      sts.ref_ok   = (div_q[15:0] >= cfg.ref_min_khz) && (div_q[15:0] <= cfg.ref_max_khz);
      sts.v_last   = v_ff == cfg.multiplier_max;
      sts.exact    = eval && (diff == 22'd0);
      sts.found    = found_ff;
      sts.out_free = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

[src/pds_ctrl.sv]
// Search sequencer: walks prescalers and multipliers, runs the divider, loads the result.
`default_nettype none

module pds_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire pds_pkg::ctrl_sts_type sts,
   output pds_pkg::ctrl_cmd_type      cmd
);
   import pds_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_PSEL = 7'b0000010,
      ST_REFW = 7'b0000100,
      ST_STEP = 7'b0001000,
      ST_FIN  = 7'b0010000,
      ST_HZW  = 7'b0100000,
      ST_OUT  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_PSEL;
            end
         end
         ST_PSEL: begin
            if (sts.p_empty) begin
               state_in = ST_FIN;
            end else if (sts.p_zero) begin
               if (sts.p_last) begin
                  state_in = ST_FIN;
               end else begin
                  cmd.p_next = 1'b1;
               end
            end else begin
               cmd.ref_start = 1'b1;
               state_in      = ST_REFW;
            end
         end
         ST_REFW: begin
            if (!sts.div_busy) begin
               if (sts.ref_ok && !sts.v_empty) begin
                  cmd.inner_init = 1'b1;
                  state_in       = ST_STEP;
               end else if (sts.p_last) begin
                  state_in = ST_FIN;
               end else begin
                  cmd.p_next = 1'b1;
                  state_in   = ST_PSEL;
               end
            end
         end
         ST_STEP: begin
            cmd.step = 1'b1;
            // an exact hit can never be beaten later: end the whole search
            if (sts.exact) begin
               state_in = ST_FIN;
            end else if (sts.v_last) begin
               if (sts.p_last) begin
                  state_in = ST_FIN;
               end else begin
                  cmd.p_next = 1'b1;
                  state_in   = ST_PSEL;
               end
            end
         end
         ST_FIN: begin
            if (sts.found) begin
               cmd.hz_start = 1'b1;
               state_in     = ST_HZW;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_HZW: begin
            if (!sts.div_busy) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

[src/pll_divider_search_unit.sv]
// PLL prescaler/multiplier search unit: top level with configuration registers.
//
// Usage:
//  - req channel: one item = {osc_khz, target_khz}, accepted when req_valid=1 and
//    req_stall=0. req_stall is low only while the sequencer is idle.
//  - rsp channel: one item per request = {no_solution, prescaler_code,
//    multiplier_code, core_clock_hz}, held in an output register until taken.
//  - csr port: write-only; csr_wr_en with csr_index 0..6 updates one register.
//    Write only while no search is in flight. Index 7 is ignored.
// One item at a time: the divider produces one quotient bit per cycle and the
// inner loop evaluates one multiplier per cycle. For each prescaler p the
// reference osc/p is divided out; a usable p then steps through its multipliers.
// A final Hz division runs only when a pair was found, and a zero prescaler is
// skipped. An exact hit ends the search early. A new item is accepted only
// once the previous search is done.
// A new item is taken while the previous result is still waiting, but its
// result is written only once the output register is free.
// Reset: synchronous, active high; clears the sequencer and the output valid
// and restores the configuration registers to their defaults.
`default_nettype none

module pll_divider_search_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire pds_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output pds_pkg::rsp_type      rsp_data,
   input  wire logic             csr_wr_en,
   input  wire logic [2:0]       csr_index,
   input  wire logic [15:0]      csr_wr_data
);
   import pds_pkg::*;

   cfg_type      cfg_ff, cfg_in;
   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   // configuration register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PRESCALER_MIN:  cfg_in.prescaler_min  = csr_wr_data[5:0];
            CSR_PRESCALER_MAX:  cfg_in.prescaler_max  = csr_wr_data[5:0];
            CSR_MULTIPLIER_MIN: cfg_in.multiplier_min = csr_wr_data[5:0];
            CSR_MULTIPLIER_MAX: cfg_in.multiplier_max = csr_wr_data[5:0];
            CSR_REF_MIN_KHZ:    cfg_in.ref_min_khz    = csr_wr_data;
            CSR_REF_MAX_KHZ:    cfg_in.ref_max_khz    = csr_wr_data;
            CSR_OUTPUT_HALVE:   cfg_in.output_halve   = csr_wr_data[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prescaler_min  <= RST_PRESCALER_MIN;
         cfg_ff.prescaler_max  <= RST_PRESCALER_MAX;
         cfg_ff.multiplier_min <= RST_MULTIPLIER_MIN;
         cfg_ff.multiplier_max <= RST_MULTIPLIER_MAX;
         cfg_ff.ref_min_khz    <= RST_REF_MIN_KHZ;
         cfg_ff.ref_max_khz    <= RST_REF_MAX_KHZ;
         cfg_ff.output_halve   <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // sequencer
   pds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath with shared divider and result register
   pds_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
